### sv/big_pkg.sv
package big_pkg;

  localparam int RANK      = 4;
  localparam int MAX_DIM   = 255;
  localparam int DIM_W     = 8;
  localparam int IDX_W     = 32;
  localparam int CFG_IDX_W = $clog2(2 * RANK) + 1;

  // register map: left lengths first, then right lengths
  localparam int CFG_LEFT_BASE  = 0;
  localparam int CFG_RIGHT_BASE = RANK;

  typedef logic [DIM_W-1:0] dim_t;

  // per-dimension lengths seen by one cell
  typedef struct packed {
    dim_t res;
    dim_t la;
    dim_t ra;
  } cell_dims_t;

  // counter control shared by all cells
  typedef struct packed {
    logic accept;
    logic restart;
    logic err;
  } cell_ctl_t;

  // partial index sums travelling down the chain; coord[0] belongs to the next cell
  typedef struct packed {
    logic [RANK-1:0][DIM_W-1:0] coord;
    logic [IDX_W-1:0]           ri;
    logic [IDX_W-1:0]           li;
    logic [IDX_W-1:0]           qi;
    logic [IDX_W-1:0]           rs;
    logic [IDX_W-1:0]           ls;
    logic [IDX_W-1:0]           qs;
    logic                       last;
    logic                       err;
  } tok_t;

  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

### sv/big_cell.sv
module big_cell
  import big_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  logic       adv,
  input  cell_dims_t dims,
  input  logic       carry_in,
  output logic       carry_out,
  output dim_t       coord_nxt,
  input  tok_t       tok_in,
  input  logic       tok_vld_in,
  output tok_t       tok_out,
  output logic       tok_vld_out
);

  dim_t             coord_r;
  logic [DIM_W:0]   c_plus;
  tok_t             tok_nxt;
  dim_t             c;
  logic [IDX_W-1:0] c_ext;
  tok_t             tok_r;
  logic             vld_r;

  // coordinate counter
  always_comb begin
    c_plus    = {1'b0, coord_r} + (DIM_W+1)'(1);
    coord_nxt = coord_r;
    carry_out = 1'b0;
    if (ctl.err || ctl.restart) begin
      coord_nxt = '0;
    end else if (carry_in) begin
      if (c_plus >= {1'b0, dims.res}) begin
        coord_nxt = '0;
        carry_out = 1'b1;
      end else begin
        coord_nxt = c_plus[DIM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r <= '0;
    end else if (ctl.accept) begin
      coord_r <= coord_nxt;
    end
  end

  // index stage for this dimension
  always_comb begin
    c       = tok_in.coord[0];
    c_ext   = IDX_W'(c);
    tok_nxt = tok_in;
    tok_nxt.coord = tok_in.coord >> DIM_W;
    tok_nxt.ri = tok_in.ri + c_ext * tok_in.rs;
    tok_nxt.li = (dims.la != DIM_W'(1)) ? tok_in.li + c_ext * tok_in.ls : tok_in.li;
    tok_nxt.qi = (dims.ra != DIM_W'(1)) ? tok_in.qi + c_ext * tok_in.qs : tok_in.qi;
    tok_nxt.rs = tok_in.rs * IDX_W'(dims.res);
    tok_nxt.ls = tok_in.ls * IDX_W'(dims.la);
    tok_nxt.qs = tok_in.qs * IDX_W'(dims.ra);
    tok_nxt.last = tok_in.last && (c == dims.res - DIM_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out     = tok_r;
  assign tok_vld_out = vld_r;

endmodule

### sv/broadcast_index_generator.sv
// channel | direction | handshake           | payload
// in_     | slave     | in_tvalid/in_tready | in_tdata: restart
// out_    | master    | out_tvalid/tready   | out_tdata: result, left, right; tlast; tuser
// cfg_    | slave     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle unless a held result stalls it; each passes one registered
// multiply-accumulate cell per dimension, innermost first, before out_tvalid rises.
// Reset: coordinates zero, all lengths 1, no clearing pass.
// A held result (out_tvalid high, out_tready low) freezes the whole chain and
// drops in_tready in the same cycle; bubbles in the chain never stall the input.
module broadcast_index_generator
  import big_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [3*IDX_W-1:0]   out_tdata,  // [31:0] result, [63:32] left, [95:64] right
  output logic                 out_tlast,
  output logic                 out_tuser,  // [0] shape_error
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  dim_t       left_dim_r  [RANK];
  dim_t       right_dim_r [RANK];
  cell_dims_t dims        [RANK];
  logic       shape_err;
  logic       adv;
  cell_ctl_t  ctl;
  logic       carry       [RANK+1];
  dim_t       coord_nxt   [RANK];
  tok_t       tok         [RANK+1];
  logic       tok_vld     [RANK+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < RANK; d++) begin
        left_dim_r[d]  <= DIM_W'(1);
        right_dim_r[d] <= DIM_W'(1);
      end
    end else if (cfg_valid) begin
      for (int d = 0; d < RANK; d++) begin
        if (cfg_index == CFG_IDX_W'(CFG_LEFT_BASE + d)) begin
          left_dim_r[d] <= cfg_data;
        end
        if (cfg_index == CFG_IDX_W'(CFG_RIGHT_BASE + d)) begin
          right_dim_r[d] <= cfg_data;
        end
      end
    end
  end

  // broadcast shape
  always_comb begin
    dim_t a;
    dim_t b;
    shape_err = 1'b0;
    for (int d = 0; d < RANK; d++) begin
      a = clamp_dim(left_dim_r[d]);
      b = clamp_dim(right_dim_r[d]);
      dims[d].la = a;
      dims[d].ra = b;
      if (a == b || b == DIM_W'(1)) begin
        dims[d].res = a;
      end else if (a == DIM_W'(1)) begin
        dims[d].res = b;
      end else begin
        dims[d].res = DIM_W'(1);
        shape_err   = 1'b1;
      end
    end
  end

  assign adv         = !out_tvalid || out_tready;
  assign in_tready   = adv;
  assign ctl.accept  = in_tvalid && adv;
  assign ctl.restart = in_tdata[0];
  assign ctl.err     = shape_err;
  assign carry[RANK] = 1'b1;

  always_comb begin
    tok[RANK]      = '0;
    tok[RANK].rs   = IDX_W'(1);
    tok[RANK].ls   = IDX_W'(1);
    tok[RANK].qs   = IDX_W'(1);
    tok[RANK].last = 1'b1;
    tok[RANK].err  = shape_err;
    for (int k = 0; k < RANK; k++) begin
      tok[RANK].coord[k] = coord_nxt[RANK-1-k];
    end
  end

  assign tok_vld[RANK] = ctl.accept;

  for (genvar d = 0; d < RANK; d++) begin : g_cell
    big_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .adv        (adv),
      .dims       (dims[d]),
      .carry_in   (carry[d+1]),
      .carry_out  (carry[d]),
      .coord_nxt  (coord_nxt[d]),
      .tok_in     (tok[d+1]),
      .tok_vld_in (tok_vld[d+1]),
      .tok_out    (tok[d]),
      .tok_vld_out(tok_vld[d])
    );
  end

  assign out_tvalid = tok_vld[0];
  assign out_tdata  = {tok[0].qi, tok[0].li, tok[0].ri};
  assign out_tlast  = tok[0].last && !tok[0].err;
  assign out_tuser  = tok[0].err;

endmodule
